### rtl/earliest_deadline_task_timer_core_assert.svh
// assertion macros for the task timer core
`ifndef EARLIEST_DEADLINE_TASK_TIMER_CORE_ASSERT_SVH
`define EARLIEST_DEADLINE_TASK_TIMER_CORE_ASSERT_SVH

// implication checked on every clock edge outside reset
`define EDT_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define EDT_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### rtl/edtt_pkg.sv
package edtt_pkg;

    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_ADD_PER  = 3'd1;
    localparam logic [2:0] OP_ADD_ONE  = 3'd2;
    localparam logic [2:0] OP_ADD_IDLE = 3'd3;
    localparam logic [2:0] OP_REMOVE   = 3'd4;

    localparam logic [1:0] KIND_NONE     = 2'd0;
    localparam logic [1:0] KIND_PERIODIC = 2'd1;
    localparam logic [1:0] KIND_ONESHOT  = 2'd2;
    localparam logic [1:0] KIND_IDLE     = 2'd3;

    localparam int SLOT_W  = 4;
    localparam int DELAY_W = 31;

    // control from the sequencer to the compare unit
    typedef struct packed {
        logic clear;
        logic step;
    } edtt_cmp_ctrl_t;

endpackage

### rtl/edtt_min_unit.sv
// shared wrapped subtract and compare, one candidate per cycle while ctrl.step is high
module edtt_min_unit
    import edtt_pkg::*;
#(
    parameter int TIME_BITS = 32,
    parameter int IDX_W     = 4
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  edtt_cmp_ctrl_t       ctrl,
    input  logic                 cand_ok,
    input  logic [IDX_W-1:0]     cand_idx,
    input  logic [TIME_BITS-1:0] cand_due,
    input  logic [TIME_BITS-1:0] ref_time,
    output logic [TIME_BITS-1:0] best_wait,
    output logic [IDX_W-1:0]     best_idx,
    output logic                 best_valid
);
    logic [TIME_BITS-1:0] best_wait_reg;
    logic [IDX_W-1:0]     best_idx_reg;
    logic                 best_valid_reg;
    logic [TIME_BITS-1:0] diff;

    assign diff = cand_due - ref_time;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            best_wait_reg  <= '1;
            best_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
        end else if (ctrl.clear) begin
            best_wait_reg  <= '1;
            best_idx_reg   <= '0;
            best_valid_reg <= 1'b0;
        end else if (ctrl.step && cand_ok && diff < best_wait_reg) begin
            best_wait_reg  <= diff;
            best_idx_reg   <= cand_idx;
            best_valid_reg <= 1'b1;
        end
    end

    assign best_wait  = best_wait_reg;
    assign best_idx   = best_idx_reg;
    assign best_valid = best_valid_reg;
endmodule

### rtl/earliest_deadline_task_timer_core.sv
// earliest-deadline task timer
// s_ channel: one command item (tick, add periodic/one-shot/idle, remove) with
// the current time. m_ channel: one result item per command.
// after reset the table is empty, no task is pending and wait_ticks is all ones.
// adds and removes rescan the table: two passes (periodic, then one-shot) over
// SLOTS entries through one wrapped subtract/compare unit, one entry a cycle.
// a tick that fires also rescans; a tick that does not fire walks the idle
// ring one entry a cycle, over at most SLOTS entries.
// with a rescan the item goes through S_EXEC and both scan passes, then S_SCAN
// latches the minimum into wait_reg and S_OUT offers the result. the next item
// is taken in the cycle after the result leaves; an unused op skips the scan.
// s_axis_tready is low while an item is in work or a result waits.
// the result sits in an output register until m_axis_tready; while the
// receiver stalls no further item is taken.
module earliest_deadline_task_timer_core
    import edtt_pkg::*;
#(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 32
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // op[2:0], slot[6:3], delay[37:7], now[69:38], zero fill
    input  logic [71:0]   s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // fired_kind[1:0], fired_slot[5:2], measured_interval[37:6],
    // wait_ticks[69:38], pending_valid[70], zero fill
    output logic [71:0]   m_axis_tdata
);
    `include "earliest_deadline_task_timer_core_assert.svh"

    localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CNT_W = $clog2(SLOTS + 1);

    typedef enum logic [2:0] {
        S_IDLE, S_EXEC, S_SCAN, S_IDLERUN, S_OUT
    } state_t;

    state_t state_reg;

    logic [SLOTS-1:0]     valid_reg;
    logic [1:0]           kind_mem [SLOTS];
    logic [DELAY_W-1:0]   intv_mem [SLOTS];
    logic [TIME_BITS-1:0] due_mem  [SLOTS];
    logic [TIME_BITS-1:0] last_mem [SLOTS];

    logic [TIME_BITS-1:0] ref_reg, wait_reg, now_reg;
    logic [IDX_W-1:0]     next_reg;
    logic                 nvalid_reg;
    logic                 ip_none_reg;
    logic [IDX_W-1:0]     ip_reg;

    logic [2:0]           op_reg;
    logic [SLOT_W-1:0]    slot_reg;
    logic [DELAY_W-1:0]   delay_reg;

    logic                 pass_reg;
    logic [CNT_W-1:0]     cnt_reg;
    logic [IDX_W-1:0]     walk_reg;

    logic [1:0]           okind_reg;
    logic [SLOT_W-1:0]    oslot_reg;
    logic [31:0]          omeas_reg;

    edtt_cmp_ctrl_t       cmp;
    logic [IDX_W-1:0]     scan_idx;
    logic                 cand_ok;
    logic [TIME_BITS-1:0] best_wait;
    logic [IDX_W-1:0]     best_idx;
    logic                 best_valid;

    logic [TIME_BITS-1:0] passed;
    logic [TIME_BITS-1:0] overdue;
    logic                 slot_in;

    assign scan_idx = cnt_reg[IDX_W-1:0];
    assign cand_ok  = valid_reg[scan_idx]
                      && kind_mem[scan_idx] == (pass_reg ? KIND_ONESHOT : KIND_PERIODIC);
    assign cmp.clear = (state_reg == S_EXEC);
    assign cmp.step  = (state_reg == S_SCAN);
    assign passed  = now_reg - ref_reg;
    assign overdue = passed - wait_reg;
    assign slot_in = ({{(32-SLOT_W){1'b0}}, slot_reg} < 32'(SLOTS));

    edtt_min_unit #(.TIME_BITS(TIME_BITS), .IDX_W(IDX_W)) u_min (
        .aclk, .aresetn, .ctrl(cmp), .cand_ok, .cand_idx(scan_idx),
        .cand_due(due_mem[scan_idx]), .ref_time(ref_reg),
        .best_wait, .best_idx, .best_valid
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            valid_reg   <= '0;
            ref_reg     <= '0;
            wait_reg    <= '1;
            next_reg    <= '0;
            nvalid_reg  <= 1'b0;
            ip_none_reg <= 1'b1;
            ip_reg      <= '0;
            pass_reg    <= 1'b0;
            cnt_reg     <= '0;
            walk_reg    <= '0;
            for (int i = 0; i < SLOTS; i++)
                last_mem[i] <= '0;
        end else begin
            unique case (state_reg)
                S_IDLE: begin
                    if (s_axis_tvalid) begin
                        op_reg    <= s_axis_tdata[2:0];
                        slot_reg  <= s_axis_tdata[6:3];
                        delay_reg <= s_axis_tdata[37:7];
                        now_reg   <= s_axis_tdata[38 +: TIME_BITS];
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC: begin
                    okind_reg <= KIND_NONE;
                    oslot_reg <= '0;
                    omeas_reg <= '0;
                    pass_reg  <= 1'b0;
                    cnt_reg   <= '0;
                    state_reg <= S_SCAN;
                    priority if (op_reg == OP_ADD_PER || op_reg == OP_ADD_ONE
                                 || op_reg == OP_ADD_IDLE) begin
                        if (slot_in) begin
                            valid_reg[slot_reg[IDX_W-1:0]] <= 1'b1;
                            kind_mem[slot_reg[IDX_W-1:0]]  <= op_reg[1:0];
                            intv_mem[slot_reg[IDX_W-1:0]]  <=
                                (op_reg == OP_ADD_IDLE) ? '0 : delay_reg;
                            due_mem[slot_reg[IDX_W-1:0]]   <= now_reg +
                                ((op_reg == OP_ADD_IDLE) ? '0
                                 : TIME_BITS'(delay_reg));
                        end
                    end else if (op_reg == OP_REMOVE) begin
                        if (slot_in)
                            valid_reg[slot_reg[IDX_W-1:0]] <= 1'b0;
                    end else if (op_reg == OP_TICK) begin
                        if (nvalid_reg && passed >= wait_reg) begin
                            okind_reg <= kind_mem[next_reg];
                            oslot_reg <= SLOT_W'(next_reg);
                            omeas_reg <= 32'(now_reg - last_mem[next_reg]);
                            last_mem[next_reg] <= now_reg;
                            if (kind_mem[next_reg] == KIND_ONESHOT)
                                valid_reg[next_reg] <= 1'b0;
                            else
                                due_mem[next_reg] <= now_reg
                                    + TIME_BITS'(intv_mem[next_reg]) - overdue;
                            ref_reg <= due_mem[next_reg];
                        end else begin
                            walk_reg  <= ip_none_reg ? '0
                                : ((32'(ip_reg) == SLOTS - 1) ? '0 : ip_reg + 1'b1);
                            state_reg <= S_IDLERUN;
                        end
                    end else begin
                        state_reg <= S_OUT;
                    end
                end
                S_SCAN: begin
                    if (32'(cnt_reg) == SLOTS - 1) begin
                        cnt_reg <= '0;
                        if (pass_reg) begin
                            cnt_reg <= CNT_W'(SLOTS);
                        end
                        pass_reg <= 1'b1;
                    end else if (32'(cnt_reg) == SLOTS) begin
                        wait_reg   <= best_wait;
                        next_reg   <= best_idx;
                        nvalid_reg <= best_valid;
                        state_reg  <= S_OUT;
                    end else begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_IDLERUN: begin
                    if (valid_reg[walk_reg] && kind_mem[walk_reg] == KIND_IDLE) begin
                        ip_reg      <= walk_reg;
                        ip_none_reg <= 1'b0;
                        okind_reg   <= KIND_IDLE;
                        oslot_reg   <= SLOT_W'(walk_reg);
                        state_reg   <= S_OUT;
                    end else if (32'(cnt_reg) == SLOTS - 1) begin
                        state_reg <= S_OUT;
                    end
                    cnt_reg  <= cnt_reg + 1'b1;
                    walk_reg <= (32'(walk_reg) == SLOTS - 1) ? '0 : walk_reg + 1'b1;
                end
                S_OUT: begin
                    if (m_axis_tready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign m_axis_tvalid = (state_reg == S_OUT);
    assign m_axis_tdata  = {1'b0, nvalid_reg, 32'(wait_reg), omeas_reg, oslot_reg, okind_reg};

    `EDT_ASSERT_IMP(a_no_overlap, aclk, aresetn, m_axis_tvalid, !s_axis_tready)
    `EDT_ASSERT_IMP(a_wait_none, aclk, aresetn, m_axis_tvalid && !nvalid_reg,
        wait_reg == '1)
    `EDT_ASSERT_NEXT(a_out_holds, aclk, aresetn, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid)
endmodule
